### hdl/gsm_pkg.sv
// ----------------------------------------------------------------------------
// gsm_pkg
// shared types, widths and constants of the grid simplex mesh generator
// ----------------------------------------------------------------------------
package gsm_pkg;

  // fixed field widths
  localparam int unsigned CELL_W = 10;
  localparam int unsigned GRID_W = 10;
  localparam int unsigned VTX_W  = 30;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned SPC_W  = 31;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned IDX_W  = 3;

  // cell count limit and fixed point format
  localparam int unsigned MAX_CELLS = 1023;
  localparam int unsigned FRAC_BITS = 16;

  localparam logic [SPC_W-1:0] SPACING_ONE = SPC_W'(1) << FRAC_BITS;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_THREE_DIM = 3'd0,
    REG_CELLS_X   = 3'd1,
    REG_CELLS_Y   = 3'd2,
    REG_CELLS_Z   = 3'd3,
    REG_SPACING   = 3'd4,
    REG_CENTER_X  = 3'd5,
    REG_CENTER_Y  = 3'd6,
    REG_CENTER_Z  = 3'd7
  } reg_idx_e;

  // what a request turns into
  typedef enum logic [1:0] {
    KIND_BAD   = 2'd0,
    KIND_POINT = 2'd1,
    KIND_TRI   = 2'd2,
    KIND_TET   = 2'd3
  } kind_e;

  // configuration register file
  typedef struct packed {
    logic              three_dim;
    logic [CELL_W-1:0] cells_x;
    logic [CELL_W-1:0] cells_y;
    logic [CELL_W-1:0] cells_z;
    logic [SPC_W-1:0]  spacing;
    logic [POS_W-1:0]  center_x;
    logic [POS_W-1:0]  center_y;
    logic [POS_W-1:0]  center_z;
  } cfg_t;

  // finished arithmetic of one request, handed to the result sequencer
  typedef struct packed {
    kind_e            kind;
    logic             parity;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [VTX_W-1:0] base;
    logic [10:0]      row;
    logic [20:0]      plane;
  } calc_t;

endpackage

### hdl/gsm_calc.sv
// ----------------------------------------------------------------------------
// gsm_calc
// three stage arithmetic pipe: range check, products, position and base index
// ----------------------------------------------------------------------------
module gsm_calc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gsm_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic [gsm_pkg::GRID_W-1:0] grid_x_i,
  input  logic [gsm_pkg::GRID_W-1:0] grid_y_i,
  input  logic [gsm_pkg::GRID_W-1:0] grid_z_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output gsm_pkg::calc_t             out_o
);
  import gsm_pkg::*;

  // floor of t/2, saturated to the signed 32 bit range
  function automatic logic [POS_W-1:0] half_sat(logic [44:0] t);
    logic [43:0] h;
    h = t[44:1];
    if (h[43:31] == {13{h[43]}}) begin
      return h[31:0];
    end else if (h[43]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

  // stage advance chain
  logic s1_v_q, s2_v_q, s3_v_q;
  logic s1_adv, s2_adv, s3_adv;

  assign s3_adv     = !s3_v_q || out_ready_i;
  assign s2_adv     = !s2_v_q || s3_adv;
  assign s1_adv     = !s1_v_q || s2_adv;
  assign in_ready_o = s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_adv) s1_v_q <= in_valid_i;
      if (s2_adv) s2_v_q <= s1_v_q;
      if (s3_adv) s3_v_q <= s2_v_q;
    end
  end

  // stage 1: range check, centered offsets and stride products
  logic        pt_ok, cl_ok;
  kind_e       kind_d;
  logic [11:0] dx_d, dy_d, dz_d;
  logic [10:0] sy_d, sz_d;
  logic [21:0] sxy_full;
  logic [20:0] gysz_full;

  always_comb begin
    pt_ok = (grid_x_i <= cfg_i.cells_x) && (grid_y_i <= cfg_i.cells_y) &&
            (!cfg_i.three_dim || (grid_z_i <= cfg_i.cells_z));
    cl_ok = (grid_x_i < cfg_i.cells_x) && (grid_y_i < cfg_i.cells_y) &&
            (!cfg_i.three_dim || (grid_z_i < cfg_i.cells_z));
    priority if (!cmd_i && !pt_ok) begin
      kind_d = KIND_BAD;
    end else if (cmd_i && !cl_ok) begin
      kind_d = KIND_BAD;
    end else if (!cmd_i) begin
      kind_d = KIND_POINT;
    end else if (cfg_i.three_dim) begin
      kind_d = KIND_TET;
    end else begin
      kind_d = KIND_TRI;
    end
  end

  assign dx_d      = {1'b0, grid_x_i, 1'b0} - {2'b00, cfg_i.cells_x};
  assign dy_d      = {1'b0, grid_y_i, 1'b0} - {2'b00, cfg_i.cells_y};
  assign dz_d      = {1'b0, grid_z_i, 1'b0} - {2'b00, cfg_i.cells_z};
  assign sy_d      = {1'b0, cfg_i.cells_y} + 11'd1;
  assign sz_d      = {1'b0, cfg_i.cells_z} + 11'd1;
  assign sxy_full  = {11'b0, sy_d} * {11'b0, sz_d};
  assign gysz_full = {11'b0, grid_y_i} * {10'b0, sz_d};

  kind_e       s1_kind_q;
  logic        s1_par_q;
  logic [9:0]  s1_gx_q, s1_gy_q, s1_gz_q;
  logic [11:0] s1_dx_q, s1_dy_q, s1_dz_q;
  logic [10:0] s1_sy_q, s1_sz_q;
  logic [20:0] s1_sxy_q, s1_gysz_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_kind_q <= kind_d;
      s1_par_q  <= grid_x_i[0] ^ grid_y_i[0];
      s1_gx_q   <= grid_x_i;
      s1_gy_q   <= grid_y_i;
      s1_gz_q   <= grid_z_i;
      s1_dx_q   <= dx_d;
      s1_dy_q   <= dy_d;
      s1_dz_q   <= dz_d;
      s1_sy_q   <= sy_d;
      s1_sz_q   <= sz_d;
      s1_sxy_q  <= sxy_full[20:0];
      s1_gysz_q <= gysz_full;
    end
  end

  // stage 2: spacing products and x stride product
  logic signed [43:0] spc_s;
  logic signed [43:0] px_d, py_d, pz_d;
  logic [20:0]        xmul;
  logic [30:0]        gxs_d;
  logic [20:0]        lo_d;

  assign spc_s = $signed({13'b0, cfg_i.spacing});
  assign px_d  = $signed(44'($signed(s1_dx_q))) * spc_s;
  assign py_d  = $signed(44'($signed(s1_dy_q))) * spc_s;
  assign pz_d  = $signed(44'($signed(s1_dz_q))) * spc_s;
  assign xmul  = cfg_i.three_dim ? s1_sxy_q : {10'b0, s1_sy_q};
  assign gxs_d = {21'b0, s1_gx_q} * {10'b0, xmul};
  assign lo_d  = cfg_i.three_dim ? (s1_gysz_q + {11'b0, s1_gz_q}) : {11'b0, s1_gy_q};

  kind_e       s2_kind_q;
  logic        s2_par_q;
  logic [43:0] s2_px_q, s2_py_q, s2_pz_q;
  logic [30:0] s2_gxs_q;
  logic [20:0] s2_lo_q;
  logic [10:0] s2_row_q;
  logic [20:0] s2_plane_q;

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s2_kind_q  <= s1_kind_q;
      s2_par_q   <= s1_par_q;
      s2_px_q    <= px_d;
      s2_py_q    <= py_d;
      s2_pz_q    <= pz_d;
      s2_gxs_q   <= gxs_d;
      s2_lo_q    <= lo_d;
      s2_row_q   <= cfg_i.three_dim ? s1_sz_q : s1_sy_q;
      s2_plane_q <= s1_sxy_q;
    end
  end

  // stage 3: add the doubled center, halve and saturate; base vertex index
  logic [44:0] tx, ty, tz;
  logic [30:0] base_sum;

  assign tx = {s2_px_q[43], s2_px_q} + {{12{cfg_i.center_x[31]}}, cfg_i.center_x, 1'b0};
  assign ty = {s2_py_q[43], s2_py_q} + {{12{cfg_i.center_y[31]}}, cfg_i.center_y, 1'b0};
  assign tz = {s2_pz_q[43], s2_pz_q} + {{12{cfg_i.center_z[31]}}, cfg_i.center_z, 1'b0};
  assign base_sum = s2_gxs_q + {10'b0, s2_lo_q};

  calc_t s3_q;

  always_ff @(posedge clk_i) begin
    if (s3_adv) begin
      s3_q.kind   <= s2_kind_q;
      s3_q.parity <= s2_par_q;
      s3_q.pos_x  <= half_sat(tx);
      s3_q.pos_y  <= half_sat(ty);
      s3_q.pos_z  <= cfg_i.three_dim ? half_sat(tz) : '0;
      s3_q.base   <= base_sum[VTX_W-1:0];
      s3_q.row    <= s2_row_q;
      s3_q.plane  <= s2_plane_q;
    end
  end

  assign out_valid_o = s3_v_q;
  assign out_o       = s3_q;

endmodule

### hdl/gsm_emit.sv
// ----------------------------------------------------------------------------
// gsm_emit
// holds one request and plays out its result words through an output register
// ----------------------------------------------------------------------------
module gsm_emit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  gsm_pkg::calc_t            in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [gsm_pkg::VTX_W-1:0] out_vertex_a_o,
  output logic [gsm_pkg::VTX_W-1:0] out_vertex_b_o,
  output logic [gsm_pkg::VTX_W-1:0] out_vertex_c_o,
  output logic [gsm_pkg::VTX_W-1:0] out_vertex_d_o,
  output logic [gsm_pkg::POS_W-1:0] out_pos_x_o,
  output logic [gsm_pkg::POS_W-1:0] out_pos_y_o,
  output logic [gsm_pkg::POS_W-1:0] out_pos_z_o,
  output logic                      out_is_last_o,
  output logic                      out_bad_request_o
);
  import gsm_pkg::*;

  // corner codes {a, b, c, d} of simplex k; corner bit 0 = +1, 1 = +row, 2 = +plane
  function automatic logic [11:0] corners(kind_e kind, logic par, logic [2:0] k);
    logic [11:0] r;
    r = '0;
    unique case (kind)
      KIND_TET: begin
        unique case (k)
          3'd0:    r = {3'd0, 3'd4, 3'd2, 3'd5};
          3'd1:    r = {3'd0, 3'd2, 3'd1, 3'd5};
          3'd2:    r = {3'd1, 3'd2, 3'd3, 3'd5};
          3'd3:    r = {3'd2, 3'd5, 3'd4, 3'd6};
          3'd4:    r = {3'd2, 3'd7, 3'd5, 3'd6};
          3'd5:    r = {3'd2, 3'd3, 3'd5, 3'd7};
          default: r = '0;
        endcase
      end
      KIND_TRI: begin
        // diagonal flips with the parity of x and y
        if (par) begin
          r = k[0] ? {3'd1, 3'd2, 3'd3, 3'd0} : {3'd0, 3'd2, 3'd1, 3'd0};
        end else begin
          r = k[0] ? {3'd0, 3'd3, 3'd1, 3'd0} : {3'd0, 3'd2, 3'd3, 3'd0};
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [VTX_W-1:0] vertex_at(logic [VTX_W-1:0] base, logic [10:0] row,
                                                 logic [20:0] plane, logic [2:0] code);
    logic [VTX_W-1:0] r;
    r = base + VTX_W'(code[0]) + (code[1] ? VTX_W'(row) : '0) +
        (code[2] ? VTX_W'(plane) : '0);
    return r;
  endfunction

  // held request
  logic             hold_v_q;
  logic [2:0]       k_q;
  kind_e            kind_q;
  logic             par_q;
  logic [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [VTX_W-1:0] base_q;
  logic [10:0]      row_q;
  logic [20:0]      plane_q;

  logic        out_v_q;
  logic        out_free;
  logic        out_load;
  logic        step_last;
  logic        hold_load;
  logic [11:0] code;

  always_comb begin
    unique case (kind_q)
      KIND_TET: step_last = (k_q == 3'd5);
      KIND_TRI: step_last = (k_q == 3'd1);
      default:  step_last = 1'b1;
    endcase
  end

  assign out_free   = !out_v_q || !out_stall_i;
  assign out_load   = hold_v_q && out_free;
  assign in_ready_o = !hold_v_q || (out_free && step_last);
  assign hold_load  = in_valid_i && in_ready_o;
  assign code       = corners(kind_q, par_q, k_q);

  // control of hold and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      k_q      <= '0;
      out_v_q  <= 1'b0;
    end else begin
      if (hold_load) begin
        hold_v_q <= 1'b1;
      end else if (out_load && step_last) begin
        hold_v_q <= 1'b0;
      end
      if (out_load) begin
        k_q <= step_last ? 3'd0 : k_q + 3'd1;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (hold_load) begin
      kind_q  <= in_i.kind;
      par_q   <= in_i.parity;
      pos_x_q <= in_i.pos_x;
      pos_y_q <= in_i.pos_y;
      pos_z_q <= in_i.pos_z;
      base_q  <= in_i.base;
      row_q   <= in_i.row;
      plane_q <= in_i.plane;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_vertex_a_o    <= '0;
      out_vertex_b_o    <= '0;
      out_vertex_c_o    <= '0;
      out_vertex_d_o    <= '0;
      out_pos_x_o       <= '0;
      out_pos_y_o       <= '0;
      out_pos_z_o       <= '0;
      out_is_last_o     <= step_last;
      out_bad_request_o <= 1'b0;
      unique case (kind_q)
        KIND_BAD: begin
          out_bad_request_o <= 1'b1;
        end
        KIND_POINT: begin
          out_pos_x_o <= pos_x_q;
          out_pos_y_o <= pos_y_q;
          out_pos_z_o <= pos_z_q;
        end
        KIND_TRI: begin
          out_vertex_a_o <= vertex_at(base_q, row_q, plane_q, code[11:9]);
          out_vertex_b_o <= vertex_at(base_q, row_q, plane_q, code[8:6]);
          out_vertex_c_o <= vertex_at(base_q, row_q, plane_q, code[5:3]);
        end
        KIND_TET: begin
          out_vertex_a_o <= vertex_at(base_q, row_q, plane_q, code[11:9]);
          out_vertex_b_o <= vertex_at(base_q, row_q, plane_q, code[8:6]);
          out_vertex_c_o <= vertex_at(base_q, row_q, plane_q, code[5:3]);
          out_vertex_d_o <= vertex_at(base_q, row_q, plane_q, code[2:0]);
        end
      endcase
    end
  end

  assign out_valid_o = out_v_q;

endmodule

### hdl/grid_simplex_mesh_generator_unit.sv
// ----------------------------------------------------------------------------
// grid_simplex_mesh_generator_unit
// point positions and cell simplices of a regular 2D or 3D grid mesh
// ----------------------------------------------------------------------------
// Usage:
//   Configure through cfg_we_i / cfg_idx_i / cfg_wdata_i while the block is
//   idle. Requests enter on the in_* channel (valid/stall), one word per
//   accepted cycle. A point request (cmd 0) gives one word with the vertex
//   position; a cell request (cmd 1) gives two triangle words in 2D or six
//   tetrahedron words in 3D. Coordinates outside the grid give one word with
//   bad_request set. is_last marks the final word of each request.
// Timing:
//   The first word of a request passes three arithmetic stages, the result
//   sequencer and the output register before it shows on out_*. The output
//   port moves one word per cycle while out_stall_i is low, and a request
//   gives one, two or six words, set by its word count in the sequencer; single
//   word requests stream at one per cycle while the output is not stalled.
// Reset and stall:
//   Reset empties the pipe and loads the default configuration. A stalled
//   output holds its word; the pipe fills up behind it and then stalls the
//   input, with no word lost or repeated.
// ----------------------------------------------------------------------------
module grid_simplex_mesh_generator_unit #(
  parameter int unsigned CELL_MAX = gsm_pkg::MAX_CELLS,
  parameter int unsigned FRAC_W   = gsm_pkg::FRAC_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gsm_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [gsm_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       in_cmd_i,
  input  logic [gsm_pkg::GRID_W-1:0] in_grid_x_i,
  input  logic [gsm_pkg::GRID_W-1:0] in_grid_y_i,
  input  logic [gsm_pkg::GRID_W-1:0] in_grid_z_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [gsm_pkg::VTX_W-1:0]  out_vertex_a_o,
  output logic [gsm_pkg::VTX_W-1:0]  out_vertex_b_o,
  output logic [gsm_pkg::VTX_W-1:0]  out_vertex_c_o,
  output logic [gsm_pkg::VTX_W-1:0]  out_vertex_d_o,
  output logic signed [gsm_pkg::POS_W-1:0] out_pos_x_o,
  output logic signed [gsm_pkg::POS_W-1:0] out_pos_y_o,
  output logic signed [gsm_pkg::POS_W-1:0] out_pos_z_o,
  output logic                       out_is_last_o,
  output logic                       out_bad_request_o
);
  import gsm_pkg::*;

  function automatic logic [CELL_W-1:0] clamp_cells(logic [CELL_W-1:0] v);
    if (v > CELL_W'(CELL_MAX)) begin
      return CELL_W'(CELL_MAX);
    end
    return v;
  endfunction

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.three_dim <= 1'b0;
      cfg_q.cells_x   <= CELL_W'(1);
      cfg_q.cells_y   <= CELL_W'(1);
      cfg_q.cells_z   <= CELL_W'(1);
      cfg_q.spacing   <= SPC_W'(1) << FRAC_W;
      cfg_q.center_x  <= '0;
      cfg_q.center_y  <= '0;
      cfg_q.center_z  <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_THREE_DIM: cfg_q.three_dim <= cfg_wdata_i[0];
        REG_CELLS_X:   cfg_q.cells_x   <= clamp_cells(cfg_wdata_i[CELL_W-1:0]);
        REG_CELLS_Y:   cfg_q.cells_y   <= clamp_cells(cfg_wdata_i[CELL_W-1:0]);
        REG_CELLS_Z:   cfg_q.cells_z   <= clamp_cells(cfg_wdata_i[CELL_W-1:0]);
        REG_SPACING:   cfg_q.spacing   <= cfg_wdata_i[SPC_W-1:0];
        REG_CENTER_X:  cfg_q.center_x  <= cfg_wdata_i;
        REG_CENTER_Y:  cfg_q.center_y  <= cfg_wdata_i;
        REG_CENTER_Z:  cfg_q.center_z  <= cfg_wdata_i;
      endcase
    end
  end

  // arithmetic pipe
  logic  calc_in_ready;
  logic  calc_valid;
  logic  emit_ready;
  calc_t calc_word;

  gsm_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (calc_in_ready),
    .cmd_i       (in_cmd_i),
    .grid_x_i    (in_grid_x_i),
    .grid_y_i    (in_grid_y_i),
    .grid_z_i    (in_grid_z_i),
    .out_valid_o (calc_valid),
    .out_ready_i (emit_ready),
    .out_o       (calc_word)
  );

  assign in_stall_o = !calc_in_ready;

  // result sequencer and output register
  gsm_emit u_emit (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (calc_valid),
    .in_ready_o        (emit_ready),
    .in_i              (calc_word),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_vertex_a_o    (out_vertex_a_o),
    .out_vertex_b_o    (out_vertex_b_o),
    .out_vertex_c_o    (out_vertex_c_o),
    .out_vertex_d_o    (out_vertex_d_o),
    .out_pos_x_o       (out_pos_x_o),
    .out_pos_y_o       (out_pos_y_o),
    .out_pos_z_o       (out_pos_z_o),
    .out_is_last_o     (out_is_last_o),
    .out_bad_request_o (out_bad_request_o)
  );

  // an error word is a lone, empty word
  a_bad_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_bad_request_o |->
      out_is_last_o && out_vertex_a_o == '0 && out_vertex_b_o == '0 &&
      out_pos_x_o == '0 && out_pos_y_o == '0)
    else $error("error word carries payload or is not last");

  // cell words carry no position
  a_cell_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_vertex_b_o != '0 |->
      out_pos_x_o == '0 && out_pos_y_o == '0 && out_pos_z_o == '0 && !out_bad_request_o)
    else $error("cell word carries a position");

  // the words of one request follow without a gap
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_is_last_o |=> out_valid_o)
    else $error("gap inside a multi word result");

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for grid_simplex_mesh_generator_unit: point and cell
// requests go in under random idling and back-pressure, every word coming
// out is compared field by field against a predicted word list
// ----------------------------------------------------------------------------
module tb;
  import gsm_pkg::*;

  // request commands
  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_CELL  = 1'b1;

  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned ITEMS_PER_PHASE = 48;
  localparam int unsigned DRAIN_LIMIT     = 20000;
  localparam int unsigned PRINT_CAP       = 100;
  localparam longint      POS_MAX         = (longint'(1) <<< 31) - 1;
  localparam longint      POS_MIN         = -(longint'(1) <<< 31);

  // one output word
  typedef struct {
    logic [VTX_W-1:0]        vertex_a;
    logic [VTX_W-1:0]        vertex_b;
    logic [VTX_W-1:0]        vertex_c;
    logic [VTX_W-1:0]        vertex_d;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    is_last;
    logic                    bad_request;
  } mesh_word_t;

  // mesh predictor and list of words still owed by the block
  class mesh_scoreboard;
    cfg_t        cfg;
    mesh_word_t  expected_words[$];
    int unsigned mismatches;

    function new();
      cfg           = '0;
      cfg.cells_x   = CELL_W'(1);
      cfg.cells_y   = CELL_W'(1);
      cfg.cells_z   = CELL_W'(1);
      cfg.spacing   = SPACING_ONE;
      mismatches    = 0;
    endfunction

    // cell counts are 10 bits wide, so they never exceed MAX_CELLS
    function void apply_reg(reg_idx_e idx, logic [CFG_W-1:0] d);
      case (idx)
        REG_THREE_DIM: cfg.three_dim = d[0];
        REG_CELLS_X:   cfg.cells_x   = d[CELL_W-1:0];
        REG_CELLS_Y:   cfg.cells_y   = d[CELL_W-1:0];
        REG_CELLS_Z:   cfg.cells_z   = d[CELL_W-1:0];
        REG_SPACING:   cfg.spacing   = d[SPC_W-1:0];
        REG_CENTER_X:  cfg.center_x  = d;
        REG_CENTER_Y:  cfg.center_y  = d;
        REG_CENTER_Z:  cfg.center_z  = d;
        default: ;
      endcase
    endfunction

    // half of (2g - cells) * spacing + 2 * center, floored, then saturated
    function logic [POS_W-1:0] axis_pos(logic [CELL_W-1:0] g, logic [CELL_W-1:0] cells,
                                        logic [POS_W-1:0] center);
      longint t, h;
      t = (2 * longint'(g) - longint'(cells)) * longint'(cfg.spacing)
          + 2 * longint'($signed(center));
      h = t >>> 1;
      if (h > POS_MAX) h = POS_MAX;
      if (h < POS_MIN) h = POS_MIN;
      return h[POS_W-1:0];
    endfunction

    // append a word to the owed list
    function void owe_word(mesh_word_t w);
      expected_words.insert(expected_words.size(), w);
    endfunction

    function void push_simplex(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                               logic [31:0] d, logic last);
      mesh_word_t w;
      w = '{default: '0};
      w.vertex_a = a[VTX_W-1:0];
      w.vertex_b = b[VTX_W-1:0];
      w.vertex_c = c[VTX_W-1:0];
      w.vertex_d = d[VTX_W-1:0];
      w.is_last  = last;
      owe_word(w);
    endfunction

    // expand one accepted request into the words it must produce
    function void note_request(logic cmd, logic [GRID_W-1:0] gx, logic [GRID_W-1:0] gy,
                               logic [GRID_W-1:0] gz);
      logic        d3, in_grid;
      mesh_word_t  w;
      logic [31:0] sy, sz, sxy, p0;
      logic [31:0] v [8];
      w  = '{default: '0};
      d3 = cfg.three_dim;
      if (cmd == CMD_POINT)
        in_grid = gx <= cfg.cells_x && gy <= cfg.cells_y && (!d3 || gz <= cfg.cells_z);
      else
        in_grid = gx < cfg.cells_x && gy < cfg.cells_y && (!d3 || gz < cfg.cells_z);

      // outside the grid: single flagged word
      if (!in_grid) begin
        w.is_last     = 1'b1;
        w.bad_request = 1'b1;
        owe_word(w);
        return;
      end

      // point position
      if (cmd == CMD_POINT) begin
        w.pos_x   = axis_pos(gx, cfg.cells_x, cfg.center_x);
        w.pos_y   = axis_pos(gy, cfg.cells_y, cfg.center_y);
        w.pos_z   = d3 ? axis_pos(gz, cfg.cells_z, cfg.center_z) : '0;
        w.is_last = 1'b1;
        owe_word(w);
        return;
      end

      // 2d cell: diagonal flips with the parity of x and y
      if (!d3) begin
        sy = 32'(cfg.cells_y) + 1;
        p0 = 32'(gx) * sy + 32'(gy);
        if (gx[0] ^ gy[0]) begin
          push_simplex(p0, p0 + sy, p0 + 1, '0, 1'b0);
          push_simplex(p0 + 1, p0 + sy, p0 + sy + 1, '0, 1'b1);
        end else begin
          push_simplex(p0, p0 + sy, p0 + sy + 1, '0, 1'b0);
          push_simplex(p0, p0 + sy + 1, p0 + 1, '0, 1'b1);
        end
        return;
      end

      // 3d cell: fixed six-tetrahedron split of the cube
      sz   = 32'(cfg.cells_z) + 1;
      sxy  = (32'(cfg.cells_y) + 1) * sz;
      v[0] = 32'(gx) * sxy + 32'(gy) * sz + 32'(gz);
      v[1] = v[0] + 1;
      v[2] = v[0] + sz;
      v[3] = v[2] + 1;
      v[4] = v[0] + sxy;
      v[5] = v[4] + 1;
      v[6] = v[4] + sz;
      v[7] = v[6] + 1;
      push_simplex(v[0], v[4], v[2], v[5], 1'b0);
      push_simplex(v[0], v[2], v[1], v[5], 1'b0);
      push_simplex(v[1], v[2], v[3], v[5], 1'b0);
      push_simplex(v[2], v[5], v[4], v[6], 1'b0);
      push_simplex(v[2], v[7], v[5], v[6], 1'b0);
      push_simplex(v[2], v[3], v[5], v[7], 1'b1);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    // compare a received word with the oldest owed one
    task check_word(mesh_word_t got);
      mesh_word_t want;
      if (expected_words.size() == 0) begin
        report("word with nothing owed");
        return;
      end
      want = expected_words.pop_front();
      compare_field("vertex_a", 32'(got.vertex_a), 32'(want.vertex_a));
      compare_field("vertex_b", 32'(got.vertex_b), 32'(want.vertex_b));
      compare_field("vertex_c", 32'(got.vertex_c), 32'(want.vertex_c));
      compare_field("vertex_d", 32'(got.vertex_d), 32'(want.vertex_d));
      compare_field("pos_x", got.pos_x, want.pos_x);
      compare_field("pos_y", got.pos_y, want.pos_y);
      compare_field("pos_z", got.pos_z, want.pos_z);
      compare_field("is_last", 32'(got.is_last), 32'(want.is_last));
      compare_field("bad_request", 32'(got.bad_request), 32'(want.bad_request));
    endtask
  endclass

  // block ports
  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [IDX_W-1:0]        cfg_idx_i   = '0;
  logic [CFG_W-1:0]        cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic                    in_cmd_i    = 1'b0;
  logic [GRID_W-1:0]       in_grid_x_i = '0;
  logic [GRID_W-1:0]       in_grid_y_i = '0;
  logic [GRID_W-1:0]       in_grid_z_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [VTX_W-1:0]        out_vertex_a_o;
  logic [VTX_W-1:0]        out_vertex_b_o;
  logic [VTX_W-1:0]        out_vertex_c_o;
  logic [VTX_W-1:0]        out_vertex_d_o;
  logic signed [POS_W-1:0] out_pos_x_o;
  logic signed [POS_W-1:0] out_pos_y_o;
  logic signed [POS_W-1:0] out_pos_z_o;
  logic                    out_is_last_o;
  logic                    out_bad_request_o;

  mesh_scoreboard sb;
  mesh_word_t     seen_word;
  logic           calm        = 1'b0;
  int unsigned    holds_asked = 0;
  int unsigned    holds_done  = 0;
  int unsigned    stall_left  = 0;

  grid_simplex_mesh_generator_unit DUT (.*);

  always #1 clk_i = ~clk_i;

  // run limit
  initial begin
    #1000000;
    $display("** grid_simplex_mesh_generator_unit: FAILED **");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 2);
    if (r < 19) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  // output stall, with a long hold-off on request
  always @(negedge clk_i) begin
    if (holds_asked != holds_done) begin
      holds_done++;
      stall_left = HOLD_CYCLES;
    end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
    end
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // output word monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_word = '{out_vertex_a_o, out_vertex_b_o, out_vertex_c_o, out_vertex_d_o,
                    out_pos_x_o, out_pos_y_o, out_pos_z_o, out_is_last_o,
                    out_bad_request_o};
      sb.check_word(seen_word);
    end
  end

  // register write, enable left high for back-to-back writes
  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    sb.apply_reg(idx, data);
  endtask

  // full register set, unused upper data bits filled with noise
  task automatic load_config(cfg_t c);
    write_reg(REG_THREE_DIM, {31'($urandom), c.three_dim});
    write_reg(REG_CELLS_X, {22'($urandom), c.cells_x});
    write_reg(REG_CELLS_Y, {22'($urandom), c.cells_y});
    write_reg(REG_CELLS_Z, {22'($urandom), c.cells_z});
    write_reg(REG_SPACING, {1'($urandom), c.spacing});
    write_reg(REG_CENTER_X, c.center_x);
    write_reg(REG_CENTER_Y, c.center_y);
    write_reg(REG_CENTER_Z, c.center_z);
    cfg_we_i <= 1'b0;
  endtask

  function automatic cfg_t make_config(logic d3, int unsigned cx, int unsigned cy,
                                       int unsigned cz, logic [SPC_W-1:0] spc,
                                       logic [POS_W-1:0] mx, logic [POS_W-1:0] my,
                                       logic [POS_W-1:0] mz);
    cfg_t c;
    c.three_dim = d3;
    c.cells_x   = cx[CELL_W-1:0];
    c.cells_y   = cy[CELL_W-1:0];
    c.cells_z   = cz[CELL_W-1:0];
    c.spacing   = spc;
    c.center_x  = mx;
    c.center_y  = my;
    c.center_z  = mz;
    return c;
  endfunction

  // one request word, held until the block takes it
  task automatic send_request(logic cmd, int unsigned gx, int unsigned gy, int unsigned gz);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_cmd_i    <= cmd;
    in_grid_x_i <= gx[GRID_W-1:0];
    in_grid_y_i <= gy[GRID_W-1:0];
    in_grid_z_i <= gz[GRID_W-1:0];
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(cmd, gx[GRID_W-1:0], gy[GRID_W-1:0], gz[GRID_W-1:0]);
    @(negedge clk_i);
  endtask

  // stop offering and wait for every owed word
  task automatic finish_batch();
    int unsigned k;
    in_valid_i <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && sb.expected_words.size() != 0; k++) @(negedge clk_i);
  endtask

  function automatic logic [CELL_W-1:0] pick_cells();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return CELL_W'($urandom_range(1, 6));
    if (r < 9) return CELL_W'($urandom_range(7, 40));
    return CELL_W'($urandom_range(0, MAX_CELLS));
  endfunction

  function automatic logic [POS_W-1:0] pick_center();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return $urandom;
      default: return POS_W'($urandom_range(0, 1 << 20)) - POS_W'(1 << 19);
    endcase
  endfunction

  function automatic cfg_t random_config(logic extreme);
    cfg_t c;
    c.three_dim = 1'($urandom_range(0, 1));
    c.cells_x   = pick_cells();
    c.cells_y   = pick_cells();
    c.cells_z   = pick_cells();
    case ($urandom_range(0, 3))
      0:       c.spacing = SPACING_ONE;
      1:       c.spacing = SPC_W'($urandom_range(0, 7));
      2:       c.spacing = SPC_W'($urandom_range(1, 1 << 20));
      default: c.spacing = SPC_W'($urandom);
    endcase
    c.center_x = pick_center();
    c.center_y = pick_center();
    c.center_z = pick_center();
    // largest grid in every direction
    if (extreme) begin
      c.three_dim = 1'b1;
      c.cells_x   = CELL_W'(MAX_CELLS);
      c.cells_y   = CELL_W'(MAX_CELLS);
      c.cells_z   = CELL_W'(MAX_CELLS);
    end
    return c;
  endfunction

  // mostly coordinates near the grid, some raw noise
  task automatic random_request();
    logic        cmd;
    int unsigned gx, gy, gz;
    cmd = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 4) != 0) begin
      gx = $urandom_range(0, sb.cfg.cells_x);
      gy = $urandom_range(0, sb.cfg.cells_y);
      gz = sb.cfg.three_dim ? $urandom_range(0, sb.cfg.cells_z) : $urandom_range(0, 1023);
    end else begin
      gx = $urandom_range(0, 1023);
      gy = $urandom_range(0, 1023);
      gz = $urandom_range(0, 1023);
    end
    send_request(cmd, gx, gy, gz);
  endtask

  task automatic directed_part();
    // reset settings: unit square in 2d
    send_request(CMD_POINT, 0, 0, 0);
    send_request(CMD_POINT, 1, 1, 0);
    send_request(CMD_POINT, 2, 0, 0);
    send_request(CMD_CELL, 0, 0, 0);
    send_request(CMD_CELL, 1, 0, 0);
    finish_batch();

    // largest 3d grid, largest spacing, centers at both range ends
    load_config(make_config(1'b1, MAX_CELLS, MAX_CELLS, MAX_CELLS, '1,
                            32'h7fff_ffff, 32'h8000_0000, '0));
    send_request(CMD_POINT, 1023, 1023, 1023);
    send_request(CMD_POINT, 0, 0, 0);
    send_request(CMD_CELL, 1022, 1022, 1022);
    send_request(CMD_CELL, 0, 0, 0);
    send_request(CMD_CELL, 1023, 0, 0);
    send_request(CMD_CELL, 0, 0, 1023);
    send_request(CMD_POINT, 0, 0, 1023);
    finish_batch();

    // zero cells along x, z ignored in 2d
    load_config(make_config(1'b0, 0, 5, MAX_CELLS, SPC_W'(1), 32'hffff_ffff, 32'h7fff_0000,
                            32'h8000_0000));
    send_request(CMD_POINT, 0, 3, 1023);
    send_request(CMD_POINT, 1, 0, 0);
    send_request(CMD_CELL, 0, 0, 0);
    send_request(CMD_POINT, 0, 6, 0);
    finish_batch();

    // odd span rounds down by half an lsb, both diagonal directions
    load_config(make_config(1'b0, 3, 4, 1, SPC_W'(1), '0, '0, '0));
    send_request(CMD_POINT, 0, 0, 0);
    send_request(CMD_CELL, 1, 0, 0);
    send_request(CMD_CELL, 1, 1, 0);
    send_request(CMD_CELL, 2, 3, 0);
    send_request(CMD_CELL, 0, 4, 0);
    finish_batch();

    // zero cells along z in 3d
    load_config(make_config(1'b1, 2, 2, 0, SPACING_ONE, '0, '0, 32'h0001_8000));
    send_request(CMD_POINT, 0, 0, 0);
    send_request(CMD_POINT, 0, 0, 1);
    send_request(CMD_CELL, 0, 0, 0);
    finish_batch();
  endtask

  // main sequence
  initial begin
    int unsigned p, n;
    sb = new();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    directed_part();

    for (p = 0; p < PHASES; p++) begin
      load_config(random_config(p == 4));
      calm = (p == 2 || p == 3);
      // long output hold-off while requests keep coming
      if (p == 3) holds_asked++;
      for (n = 0; n < ITEMS_PER_PHASE; n++) random_request();
      finish_batch();
    end
    calm = 1'b0;

    repeat (12) @(negedge clk_i);
    if (sb.expected_words.size() != 0)
      sb.report($sformatf("%0d words never arrived", sb.expected_words.size()));

    if (sb.mismatches == 0) begin
      $display("** grid_simplex_mesh_generator_unit: PASSED **");
    end else begin
      $display("** grid_simplex_mesh_generator_unit: FAILED **");
    end
    $finish;
  end

endmodule
